// ===== hw/rtl/wto_pkg.sv =====
// ----------------------------------------------------------------------------
// wto_pkg
// shared types and constants of the wavetable oscillator with effects
// ----------------------------------------------------------------------------
package wto_pkg;

    localparam int INC_W     = 26;   // phase increment register
    localparam int CFG_W     = 26;   // configuration data, widest register
    localparam int PF_W      = 32;   // pitch factor, Q2.30
    localparam int FADE_W    = 25;   // fade level, Q1.24
    localparam int SAMPLE_W  = 16;   // Q1.15 sample
    localparam int POS_W     = 10;   // reported table position
    localparam int GAIN_W    = 16;   // output gain, Q1.15
    localparam int MUL_W     = 33;   // shared multiplier operand, signed
    localparam int PROD_W    = 65;   // shared multiplier product, signed

    localparam logic [PF_W-1:0]   PF_ONE    = 32'd1073741824;
    localparam logic [PF_W-1:0]   PF_DROP   = 32'd1073634450;   // 0.9999
    localparam logic [PF_W-1:0]   PF_SLIDE  = 32'd1073795511;   // 1.00005
    localparam logic [FADE_W-1:0] FADE_ONE  = 25'd16777216;
    localparam logic [FADE_W-1:0] FADE_STEP = 25'd1678;         // 0.0001
    localparam logic [GAIN_W-1:0] GAIN_FULL = 16'd32768;
    localparam logic [31:0]       HASH_MUL0 = 32'd2654435761;
    localparam logic [31:0]       HASH_MUL1 = 32'h2C1B3C6D;

    typedef enum logic [1:0] {
        CFG_INCREMENT = 2'd0,
        CFG_WAVE      = 2'd1,
        CFG_EFFECT    = 2'd2,
        CFG_GAIN      = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        WAVE_TRI    = 2'd0,
        WAVE_SQUARE = 2'd1,
        WAVE_SAW    = 2'd2,
        WAVE_NOISE  = 2'd3
    } t_wave;

    typedef enum logic [2:0] {
        EFF_NONE     = 3'd0,
        EFF_DROP     = 3'd1,
        EFF_SLIDE    = 3'd2,
        EFF_FADE_IN  = 3'd3,
        EFF_FADE_OUT = 3'd4
    } t_effect;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PSTEP,
        S_PFACT,
        S_PUPD,
        S_ACC,
        S_WAVE,
        S_HASH2,
        S_HASH3,
        S_FADE,
        S_FADEQ,
        S_GAIN,
        S_GAINQ
    } t_state;

endpackage

// ===== hw/rtl/wto_wave.sv =====
// ----------------------------------------------------------------------------
// wto_wave
// triangle, square and sawtooth shapes from the integer table index
// ----------------------------------------------------------------------------
module wto_wave
    import wto_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  t_wave                       i_wave,
    input  logic [TABLE_BITS-1:0]       i_index,
    output logic signed [SAMPLE_W-1:0]  o_sample
);

    logic [17:0]         w_quad;     // 4x in Q.15
    logic signed [18:0]  w_quad_s;
    logic signed [18:0]  w_tri;
    logic [1:0]          w_seg;
    logic [15:0]         w_saw;

    assign w_quad   = 18'(i_index) << (17 - TABLE_BITS);
    assign w_quad_s = signed'({1'b0, w_quad});
    assign w_seg    = i_index[TABLE_BITS-1 -: 2];
    assign w_saw    = 16'(i_index) << (16 - TABLE_BITS);

    always_comb begin
        unique case (w_seg)
            2'b00:         w_tri = w_quad_s;
            2'b01, 2'b10:  w_tri = 19'sd65536 - w_quad_s;
            default:       w_tri = w_quad_s - 19'sd131072;
        endcase
    end

    always_comb begin
        unique case (i_wave)
            WAVE_TRI: begin
                // peak of +1.0 saturates
                if (w_tri > 19'sd32767) o_sample = 16'sh7FFF;
                else                    o_sample = w_tri[15:0];
            end
            WAVE_SQUARE: o_sample = i_index[TABLE_BITS-1] ? 16'sh8000 : 16'sh7FFF;
            WAVE_SAW:    o_sample = {~w_saw[15], w_saw[14:0]};
            WAVE_NOISE:  o_sample = '0;
        endcase
    end

endmodule

// ===== hw/rtl/wavetable_oscillator_with_effects.sv =====
// ----------------------------------------------------------------------------
// wavetable_oscillator_with_effects
// dds wavetable oscillator with pitch drop/slide and fade in/out effects
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_advance
//  out     | output    | o_out_valid / i_out_ready | o_audio_out, o_table_position
//  cfg     | input     | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
//  a tick request holds ready low through pitch (drop or slide), phase, wave, hash (noise),
//  fade (fade in or out) and gain steps; each multiply on the shared 33x33 unit is one step
//  a request with advance low is taken and dropped with no result
//  a finished sample waits in the output register; the next request computes
//  meanwhile and stalls in its last step only while that register is still full
//  synchronous active-low reset clears config, phase and fade level and sets the pitch factor to one
//
module wavetable_oscillator_with_effects
    import wto_pkg::*;
#(
    parameter int TABLE_BITS      = 10,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_advance,

    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [SAMPLE_W-1:0]  o_audio_out,
    output logic [POS_W-1:0]            o_table_position,

    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data
);

    localparam int ACC_W = TABLE_BITS + PHASE_FRAC_BITS;
    localparam int SUM_W = ((ACC_W > INC_W) ? ACC_W : INC_W) + 1;

    // state and configuration
    t_state                       r_state, n_state;
    logic [INC_W-1:0]             r_inc;
    t_wave                        r_wave;
    t_effect                      r_effect;
    logic [GAIN_W-1:0]            r_gain;
    logic [ACC_W-1:0]             r_phase;
    logic [PF_W-1:0]              r_pf;
    logic [FADE_W-1:0]            r_fade;
    logic                         r_out_valid;

    // datapath
    logic [INC_W-1:0]             r_step;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [SAMPLE_W-1:0]   r_samp;
    logic signed [SAMPLE_W-1:0]   r_audio;
    logic [POS_W-1:0]             r_pos;

    // shared multiplier
    logic signed [MUL_W-1:0]      w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]     w_mul;
    logic                         w_mul_en;

    logic                         w_accept;
    logic                         w_pitch_fx;
    logic                         w_fade_fx;
    logic [TABLE_BITS-1:0]        w_idx;
    logic signed [SAMPLE_W-1:0]   w_shape;
    logic [INC_W-1:0]             w_step_sat;
    logic [PF_W-1:0]              w_pf_sat;
    logic [31:0]                  w_h1, w_h2;
    logic signed [PROD_W-1:0]     w_fade_sum, w_gain_sum;
    logic [GAIN_W-1:0]            w_gain;
    logic [FADE_W:0]              w_fade_up;
    logic [FADE_W-1:0]            w_fade_next;
    logic [SUM_W-1:0]             w_phase_sum;
    logic [2:0]                   w_cfg_eff;
    t_effect                      w_cfg_effect;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_pitch_fx  = (r_effect == EFF_DROP) || (r_effect == EFF_SLIDE);
    assign w_fade_fx   = (r_effect == EFF_FADE_IN) || (r_effect == EFF_FADE_OUT);
    assign w_idx       = r_phase[ACC_W-1 -: TABLE_BITS];
    assign w_gain      = (r_gain > GAIN_FULL) ? GAIN_FULL : r_gain;

    // waveform shapes other than noise
    wto_wave #(
        .TABLE_BITS (TABLE_BITS)
    ) u_wave (
        .i_wave   (r_wave),
        .i_index  (w_idx),
        .o_sample (w_shape)
    );

    // product post-processing: shifts with saturation
    assign w_step_sat = (|r_prod[64:56]) ? '1 : r_prod[55:30];
    assign w_pf_sat   = (|r_prod[64:62]) ? '1 : r_prod[61:30];
    // noise hash rounds
    assign w_h1       = r_prod[31:0] ^ (r_prod[31:0] >> 15);
    assign w_h2       = r_prod[31:0] ^ (r_prod[31:0] >> 12);
    // divide by a power of two, truncating toward zero
    assign w_fade_sum = r_prod + (r_prod[PROD_W-1] ? 65'sd16777215 : 65'sd0);
    assign w_gain_sum = r_prod + (r_prod[PROD_W-1] ? 65'sd32767 : 65'sd0);

    // fade level step, clamped to 0..1
    assign w_fade_up = 26'(r_fade) + 26'(FADE_STEP);
    always_comb begin
        if (r_effect == EFF_FADE_IN) begin
            w_fade_next = (w_fade_up > 26'(FADE_ONE)) ? FADE_ONE : w_fade_up[FADE_W-1:0];
        end else begin
            w_fade_next = (r_fade < FADE_STEP) ? '0 : r_fade - FADE_STEP;
        end
    end

    // phase wraps by masking to the accumulator width
    assign w_phase_sum = SUM_W'(r_phase) + SUM_W'(r_step);

    assign w_mul = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // config effect codes above fade out act as none
    assign w_cfg_eff    = i_cfg_data[2:0];
    assign w_cfg_effect = (w_cfg_eff > 3'(EFF_FADE_OUT)) ? EFF_NONE : t_effect'(w_cfg_eff);

    // sequencer: next state and multiplier operands
    always_comb begin
        n_state  = r_state;
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_advance) begin
                    n_state = w_pitch_fx ? S_PSTEP : S_ACC;
                end
            end
            S_PSTEP: begin
                // effective step = increment * pitch factor
                w_mul_a  = signed'({7'b0, r_inc});
                w_mul_b  = signed'({1'b0, r_pf});
                w_mul_en = 1'b1;
                n_state  = S_PFACT;
            end
            S_PFACT: begin
                // pitch factor times drop or slide constant
                w_mul_a  = signed'({1'b0, r_pf});
                w_mul_b  = signed'({1'b0, (r_effect == EFF_DROP) ? PF_DROP : PF_SLIDE});
                w_mul_en = 1'b1;
                n_state  = S_PUPD;
            end
            S_PUPD:  n_state = S_ACC;
            S_ACC:   n_state = S_WAVE;
            S_WAVE: begin
                if (r_wave == WAVE_NOISE) begin
                    w_mul_a  = signed'(33'(w_idx));
                    w_mul_b  = signed'({1'b0, HASH_MUL0});
                    w_mul_en = 1'b1;
                    n_state  = S_HASH2;
                end else begin
                    n_state  = w_fade_fx ? S_FADE : S_GAIN;
                end
            end
            S_HASH2: begin
                w_mul_a  = signed'({1'b0, w_h1});
                w_mul_b  = signed'({1'b0, HASH_MUL1});
                w_mul_en = 1'b1;
                n_state  = S_HASH3;
            end
            S_HASH3: n_state = w_fade_fx ? S_FADE : S_GAIN;
            S_FADE: begin
                w_mul_a  = MUL_W'(r_samp);
                w_mul_b  = signed'({8'b0, r_fade});
                w_mul_en = 1'b1;
                n_state  = S_FADEQ;
            end
            S_FADEQ: n_state = S_GAIN;
            S_GAIN: begin
                w_mul_a  = MUL_W'(r_samp);
                w_mul_b  = signed'({17'b0, w_gain});
                w_mul_en = 1'b1;
                n_state  = S_GAINQ;
            end
            S_GAINQ: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control state, configuration and effect state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc       <= '0;
            r_wave      <= WAVE_TRI;
            r_effect    <= EFF_NONE;
            r_gain      <= '0;
            r_phase     <= '0;
            r_pf        <= PF_ONE;
            r_fade      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_PUPD)  r_pf    <= w_pf_sat;
            if (r_state == S_ACC)   r_phase <= w_phase_sum[ACC_W-1:0];
            if (r_state == S_FADE)  r_fade  <= w_fade_next;

            if (r_state == S_GAINQ && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // writes must arrive only while idle; the block itself does not enforce this
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_INCREMENT: begin
                        r_inc   <= i_cfg_data[INC_W-1:0];
                        r_phase <= '0;
                    end
                    CFG_WAVE:   r_wave <= t_wave'(i_cfg_data[1:0]);
                    CFG_EFFECT: begin
                        r_effect <= w_cfg_effect;
                        r_pf     <= PF_ONE;
                        r_fade   <= (w_cfg_effect == EFF_FADE_OUT) ? FADE_ONE : '0;
                    end
                    CFG_GAIN:   r_gain <= i_cfg_data[GAIN_W-1:0];
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_mul_en) r_prod <= w_mul;
        if (w_accept) r_step <= r_inc;
        unique case (r_state)
            S_PFACT: r_step <= w_step_sat;
            S_WAVE:  r_samp <= w_shape;
            S_HASH3: r_samp <= {~w_h2[31], w_h2[30:16]};
            S_FADEQ: r_samp <= w_fade_sum[39:24];
            default: ;
        endcase
        if (r_state == S_GAINQ && (!r_out_valid || i_out_ready)) begin
            // gain never exceeds one, so the quotient stays in range
            r_audio <= w_gain_sum[30:15];
            r_pos   <= POS_W'(w_idx);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_audio_out      = r_audio;
    assign o_table_position = r_pos;

`ifndef SYNTHESIS
    a_busy_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_advance) |=> !o_in_ready)
        else $error("ready stayed high after a tick request");

    a_fade_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fade <= FADE_ONE)
        else $error("fade level above one");

    a_pitch_only_with_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUPD) |-> (r_effect == EFF_DROP || r_effect == EFF_SLIDE))
        else $error("pitch factor updated without a pitch effect");

    a_out_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_GAINQ)
        else $error("output valid raised outside the final step");

    a_idle_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_cfg_we) |=> $stable(r_phase))
        else $error("phase moved while idle");
`endif

endmodule

// ===== verif/wavetable_oscillator_with_effects_tb.sv =====
// ----------------------------------------------------------------------------
// wavetable_oscillator_with_effects_tb
// self-checking bench: tick requests in, samples out, each sample compared
// with its typed-in value, else an in-bench model of phase, pitch, fade and gain arithmetic
// ----------------------------------------------------------------------------
module wavetable_oscillator_with_effects_tb
    import wto_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // model geometry, matches the default build of the block
    localparam int     TBL_BITS    = 10;
    localparam longint TBL_N       = 64'd1 << TBL_BITS;
    localparam longint FADE_UNIT   = FADE_ONE;
    localparam int     FADE_INC    = FADE_STEP;
    localparam longint GAIN_UNIT   = GAIN_FULL;
    localparam logic [INC_W-1:0] INC_MAX = '1;

    localparam int HOLD_CYCLES = 20;        // margin over the longest tick
    localparam int CYCLE_LIMIT = 8000000;
    localparam int RAND_TARGET = 1800;

    // one produced sample
    typedef struct packed {
        logic [SAMPLE_W-1:0] audio;
        logic [POS_W-1:0]    pos;
    } t_sample;

    // per tick request: optionally a hand-typed expected sample
    typedef struct {
        bit      pinned;
        t_sample value;
    } t_tick_pin;

    typedef enum logic { ROW_REG, ROW_TICK } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        t_cfg_index         reg_idx;
        logic [CFG_W-1:0]   data;
        logic               adv;
        int                 reps;
        bit                 pin;
        logic [SAMPLE_W-1:0] audio;
        logic [POS_W-1:0]   pos;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // dut inputs, all driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_advance = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_audio_out;
    logic [POS_W-1:0]           o_table_position;
    logic                       i_cfg_we = 1'b0;
    logic [1:0]                 i_cfg_index = 2'd0;
    logic [CFG_W-1:0]           i_cfg_data = '0;

    wavetable_oscillator_with_effects i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_advance        (i_advance),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_audio_out      (o_audio_out),
        .o_table_position (o_table_position),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // oscillator model: register copies and running state, reset values
    // ------------------------------------------------------------------------
    logic [INC_W-1:0]  reg_inc    = '0;
    t_wave             reg_wave   = WAVE_TRI;
    t_effect           reg_effect = EFF_NONE;
    logic [GAIN_W-1:0] reg_gain   = '0;
    logic [INC_W-1:0]  phase_acc  = '0;
    logic [PF_W-1:0]   pitch_q30  = PF_ONE;
    int                fade_q24   = 0;

    t_sample   predicted_samples[$];
    t_tick_pin tick_pins[$];

    int  errors = 0;
    int  rand_results = 0;
    bit  src_burst = 1'b0;     // sender: no gaps between requests
    bit  sink_burst = 1'b0;    // receiver: never stalls

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // generated waveform at one table index, q1.15
    function automatic longint wave_sample(input t_wave w, input logic [TBL_BITS-1:0] idx);
        longint     i;
        longint     quad;
        logic [31:0] h;
        i = idx;
        quad = (i * 131072) >>> TBL_BITS;      // 4x in q.15
        case (w)
            WAVE_TRI: begin
                if (4 * i < TBL_N) return clip16(quad);
                if (4 * i < 3 * TBL_N) return clip16(65536 - quad);
                return clip16(quad - 131072);
            end
            WAVE_SQUARE: return (2 * i < TBL_N) ? 32767 : -32768;
            WAVE_SAW:    return clip16(((i * 65536) >>> TBL_BITS) - 32768);
            default: begin
                // fixed index hash, top half taken as a signed sample
                h = 32'(idx) * HASH_MUL0;
                h = h ^ (h >> 15);
                h = h * HASH_MUL1;
                h = h ^ (h >> 12);
                return longint'(h[31:16]) - 32768;
            end
        endcase
    endfunction

    function automatic void apply_register(input logic [1:0] idx, input logic [CFG_W-1:0] d);
        logic [2:0] e;
        case (idx)
            CFG_INCREMENT: begin
                reg_inc = d[INC_W-1:0];
                phase_acc = '0;
            end
            CFG_WAVE: reg_wave = t_wave'(d[1:0]);
            CFG_EFFECT: begin
                // codes above fade out fall back to no effect
                e = d[2:0];
                reg_effect = (e > EFF_FADE_OUT) ? EFF_NONE : t_effect'(e);
                pitch_q30 = PF_ONE;
                fade_q24 = (reg_effect == EFF_FADE_OUT) ? int'(FADE_UNIT) : 0;
            end
            default: reg_gain = d[GAIN_W-1:0];
        endcase
    endfunction

    // advances the model by one sample period and returns the sample
    function automatic t_sample next_sample();
        longint unsigned stp;
        longint unsigned pf;
        longint unsigned k;
        longint unsigned inc;
        longint          s;
        longint          g;
        int              nf;
        logic [TBL_BITS-1:0] idx;
        t_sample         r;

        stp = reg_inc;
        if (reg_effect == EFF_DROP || reg_effect == EFF_SLIDE) begin
            // step scaled by the pitch factor, then the factor moves on
            inc = reg_inc;
            pf = pitch_q30;
            k = (reg_effect == EFF_DROP) ? PF_DROP : PF_SLIDE;
            stp = (inc * pf) >> 30;
            if (stp > INC_MAX) stp = INC_MAX;
            pf = (pf * k) >> 30;
            if (pf > 64'hFFFF_FFFF) pf = 64'hFFFF_FFFF;
            pitch_q30 = pf[PF_W-1:0];
        end

        phase_acc = phase_acc + stp[INC_W-1:0];     // wraps with the table
        idx = phase_acc[INC_W-1 -: TBL_BITS];
        s = wave_sample(reg_wave, idx);

        if (reg_effect == EFF_FADE_IN || reg_effect == EFF_FADE_OUT) begin
            s = (s * fade_q24) / FADE_UNIT;
            nf = fade_q24 + ((reg_effect == EFF_FADE_IN) ? FADE_INC : -FADE_INC);
            if (nf < 0) nf = 0;
            if (nf > FADE_UNIT) nf = int'(FADE_UNIT);
            fade_q24 = nf;
        end

        g = (reg_gain > GAIN_FULL) ? GAIN_UNIT : longint'(reg_gain);
        s = clip16((s * g) / 32768);

        r.audio = s[SAMPLE_W-1:0];
        r.pos = idx;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 50) $display("ERROR at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // watch both channels and the register port at every edge; values read
    // here are the ones the block saw at that edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : track
        t_tick_pin tp;
        t_sample   pred;
        t_sample   want;
        if (i_rst_n) begin
            if (i_cfg_we) apply_register(i_cfg_index, i_cfg_data);

            // accepted tick request: advance low gives no sample
            if (i_in_valid && o_in_ready) begin
                tp = '{pinned: 1'b0, value: '0};
                if (tick_pins.size() != 0) tp = tick_pins.pop_front();
                if (i_advance) begin
                    pred = next_sample();
                    predicted_samples.push_back(tp.pinned ? tp.value : pred);
                end
            end

            // accepted sample against the oldest prediction
            if (o_out_valid && i_out_ready) begin
                if (predicted_samples.size() == 0) begin
                    report_mismatch("sample with no tick request pending");
                end else begin
                    want = predicted_samples.pop_front();
                    if (o_audio_out !== want.audio)
                        report_mismatch($sformatf("audio_out %0d, expected %0d",
                            o_audio_out, $signed(want.audio)));
                    if (o_table_position !== want.pos)
                        report_mismatch($sformatf("table_position %0d, expected %0d",
                            o_table_position, want.pos));
                end
            end
        end
    end

    // receiver: random stall before every sample, none while sink_burst
    initial begin : sink
        int w;
        forever begin
            w = sink_burst ? 0 : $urandom_range(0, 12);
            if (w != 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // cycle budget for the whole run
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // one tick request; valid stays up across back-to-back requests
    task automatic send_tick(input logic adv, input bit pin, input t_sample val);
        int        gap;
        t_tick_pin tp;
        gap = src_burst ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tp.pinned = pin;
        tp.value = val;
        tick_pins.push_back(tp);
        i_in_valid <= 1'b1;
        i_advance <= adv;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    // write enable is left high so writes can go back to back
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
    endtask

    // stop sending, let every sample drain, then wait out the hold margin
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (predicted_samples.size() != 0 || tick_pins.size() != 0)
            @(posedge i_clk);
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    // one phase: fresh register settings, then a run of tick requests
    task automatic random_phase(input int n_adv, input bit all_regs, input bit fast,
                                input int effect_pick);
        logic [CFG_W-1:0] d;
        bit   wrote;
        int   done;
        logic adv;

        wait_idle();
        wrote = 1'b0;
        done = 0;
        src_burst = fast || ($urandom_range(0, 4) == 0);
        sink_burst = fast || ($urandom_range(0, 4) == 0);

        if (all_regs || $urandom_range(0, 1) == 1) begin
            // mostly steps that move the index visibly, plus the extremes
            case ($urandom_range(0, 7))
                0:       d = '0;
                1:       d = '1;
                2, 3:    d = CFG_W'($urandom);
                default: d = CFG_W'($urandom_range(1, 1 << 22));
            endcase
            write_reg(CFG_INCREMENT, d);
            wrote = 1'b1;
        end
        if (all_regs || $urandom_range(0, 1) == 1) begin
            d = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 3));
            write_reg(CFG_WAVE, d);
            wrote = 1'b1;
        end
        if (effect_pick >= 0) begin
            write_reg(CFG_EFFECT, CFG_W'(effect_pick));
            wrote = 1'b1;
        end else if (all_regs || $urandom_range(0, 1) == 1) begin
            // includes the unused codes above fade out
            d = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 7));
            write_reg(CFG_EFFECT, d);
            wrote = 1'b1;
        end
        if (all_regs || $urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 7))
                0:       d = '0;
                1:       d = CFG_W'(GAIN_FULL);
                2:       d = CFG_W'(16'hFFFF);
                3:       d = CFG_W'($urandom);
                default: d = CFG_W'($urandom_range(0, 32768));
            endcase
            write_reg(CFG_GAIN, d);
            wrote = 1'b1;
        end
        if (wrote) i_cfg_we <= 1'b0;

        // about one request in ten is a dropped tick
        while (done < n_adv) begin
            adv = ($urandom_range(0, 9) != 0);
            send_tick(adv, 1'b0, '0);
            if (adv) done++;
        end
        rand_results += done;
    endtask

    // ------------------------------------------------------------------------
    // directed rows; audio/pos typed in only where obvious, else modeled
    // ------------------------------------------------------------------------
    localparam int N_DIRECTED = 35;

    t_stim_row directed_rows [N_DIRECTED] = '{
        // out of reset: zero gain, phase at zero
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 1, 1'b1, 16'h0000, 10'd0},
        // dropped tick, no sample
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b0, 1, 1'b0, 16'h0000, 10'd0},
        '{ROW_REG,  CFG_GAIN,      CFG_W'(GAIN_FULL),   1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_REG,  CFG_WAVE,      CFG_W'(WAVE_SQUARE), 1'b0, 0, 1'b0, 16'h0000, 10'd0},
        // square at index 0: +1.0 saturated
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 1, 1'b1, 16'h7FFF, 10'd0},
        '{ROW_REG,  CFG_WAVE,      CFG_W'(WAVE_SAW),    1'b0, 0, 1'b0, 16'h0000, 10'd0},
        // sawtooth at index 0: -1.0
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 1, 1'b1, 16'h8000, 10'd0},
        // gain above full scale acts as full scale
        '{ROW_REG,  CFG_GAIN,      CFG_W'(16'hFFFF),    1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 1, 1'b1, 16'h8000, 10'd0},
        // half-table step: index 512 then wrap back to 0
        '{ROW_REG,  CFG_INCREMENT, CFG_W'(512 << 16),   1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_REG,  CFG_WAVE,      CFG_W'(WAVE_SQUARE), 1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 1, 1'b1, 16'h8000, 10'd512},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 1, 1'b1, 16'h7FFF, 10'd0},
        // triangle peak at quarter table saturates, trough at three quarters
        '{ROW_REG,  CFG_INCREMENT, CFG_W'(256 << 16),   1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_REG,  CFG_WAVE,      CFG_W'(WAVE_TRI),    1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 1, 1'b1, 16'h7FFF, 10'd256},
        '{ROW_REG,  CFG_INCREMENT, CFG_W'(768 << 16),   1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 1, 1'b1, 16'h8000, 10'd768},
        // largest step: lands on the last index, then wraps past a table length
        '{ROW_REG,  CFG_INCREMENT, '1,                  1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_REG,  CFG_WAVE,      CFG_W'(WAVE_SAW),    1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 1, 1'b1, 16'h7FC0, 10'd1023},
        '{ROW_REG,  CFG_WAVE,      CFG_W'(WAVE_NOISE),  1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 3, 1'b0, 16'h0000, 10'd0},
        // pitch effects, step saturates once the factor passes one
        '{ROW_REG,  CFG_EFFECT,    CFG_W'(EFF_DROP),    1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 3, 1'b0, 16'h0000, 10'd0},
        '{ROW_REG,  CFG_EFFECT,    CFG_W'(EFF_SLIDE),   1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 3, 1'b0, 16'h0000, 10'd0},
        // level effects
        '{ROW_REG,  CFG_WAVE,      CFG_W'(WAVE_TRI),    1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_REG,  CFG_EFFECT,    CFG_W'(EFF_FADE_IN), 1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 2, 1'b0, 16'h0000, 10'd0},
        '{ROW_REG,  CFG_EFFECT,    CFG_W'(EFF_FADE_OUT), 1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 2, 1'b0, 16'h0000, 10'd0},
        // unused effect code behaves as no effect
        '{ROW_REG,  CFG_EFFECT,    CFG_W'(3'd7),        1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_REG,  CFG_GAIN,      '0,                  1'b0, 0, 1'b0, 16'h0000, 10'd0},
        '{ROW_TICK, CFG_INCREMENT, '0, 1'b1, 2, 1'b0, 16'h0000, 10'd0}
    };

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : run
        bit      cfg_open;
        t_sample val;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: register rows wait for an idle block first
        cfg_open = 1'b0;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_REG) begin
                if (!cfg_open) begin
                    wait_idle();
                    cfg_open = 1'b1;
                end
                write_reg(directed_rows[k].reg_idx, directed_rows[k].data);
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                val.audio = directed_rows[k].audio;
                val.pos = directed_rows[k].pos;
                repeat (directed_rows[k].reps)
                    send_tick(directed_rows[k].adv, directed_rows[k].pin, val);
            end
        end

        // random phases with random settings and handshake gaps
        random_phase($urandom_range(5, 60), 1'b1, 1'b0, -1);
        while (rand_results < RAND_TARGET)
            random_phase($urandom_range(5, 60), 1'b0, 1'b0, -1);

        // short runs at full rate for each level effect and the slide effect
        random_phase(60, 1'b1, 1'b1, EFF_FADE_IN);
        random_phase(60, 1'b1, 1'b1, EFF_FADE_OUT);
        random_phase(60, 1'b1, 1'b1, EFF_SLIDE);

        // drain and watch for stray samples
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (predicted_samples.size() != 0)
            report_mismatch($sformatf("%0d samples never arrived", predicted_samples.size()));

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
